FILE: design/cog_pkg.sv
`timescale 1ns / 1ps

package cog_pkg;

	localparam int GENOME_BITS_DEF  = 36;
	localparam int READ_LEN_MAX_DEF = 4096;

	// Width of the length field on the result channel.
	localparam int OP_LEN_W = 37;
	localparam int JC_W     = 4;

	localparam int NUM_SLOTS = 5;

	// Fixed places in the per-block operation list, in emission order.
	localparam int SLOT_LEAD  = 0;
	localparam int SLOT_GAP   = 1;
	localparam int SLOT_TAILG = 2;
	localparam int SLOT_MATCH = 3;
	localparam int SLOT_CLIP  = 4;

	localparam logic signed [JC_W-1:0] MATE_GAP_CODE = -4'sd3;

	typedef enum logic [2:0] {
		OP_M = 3'd0,
		OP_I = 3'd1,
		OP_D = 3'd2,
		OP_N = 3'd3,
		OP_S = 3'd4,
		OP_P = 3'd5
	} op_kind_t;

endpackage

FILE: design/cog_blk_if.sv
`timescale 1ns / 1ps

interface cog_blk_if #(
	parameter int GENOME_BITS  = cog_pkg::GENOME_BITS_DEF,
	parameter int READ_LEN_MAX = cog_pkg::READ_LEN_MAX_DEF
);
	localparam int ReadW = $clog2(READ_LEN_MAX) + 1;
	localparam int MateW = $clog2(READ_LEN_MAX);

	logic                             valid;
	logic                             ready;
	logic                             first_block;
	logic                             last_block;
	logic [GENOME_BITS-1:0]           genome_start;
	logic [ReadW-1:0]                 read_start;
	logic [MateW-1:0]                 block_length;
	logic signed [cog_pkg::JC_W-1:0]  junction_code;
	logic                             annotated;
	logic                             strand;
	logic [MateW-1:0]                 mate1_length;
	logic [MateW-1:0]                 mate2_length;
	logic [ReadW-1:0]                 pair_length;

	modport source (
		output valid, first_block, last_block, genome_start, read_start, block_length,
		       junction_code, annotated, strand, mate1_length, mate2_length, pair_length,
		input  ready
	);

	modport sink (
		input  valid, first_block, last_block, genome_start, read_start, block_length,
		       junction_code, annotated, strand, mate1_length, mate2_length, pair_length,
		output ready
	);
endinterface

FILE: design/cog_op_if.sv
`timescale 1ns / 1ps

interface cog_op_if;
	logic                                valid;
	logic                                ready;
	logic [2:0]                          op_kind;
	logic signed [cog_pkg::OP_LEN_W-1:0] op_length;
	logic                                last_op;

	modport source (
		output valid, op_kind, op_length, last_op,
		input  ready
	);

	modport sink (
		input  valid, op_kind, op_length, last_op,
		output ready
	);
endinterface

FILE: design/cog_cfg_if.sv
`timescale 1ns / 1ps

interface cog_cfg_if;
	logic valid;
	logic ready;
	logic paired_end;

	modport source (
		output valid, paired_end,
		input  ready
	);

	modport sink (
		input  valid, paired_end,
		output ready
	);
endinterface

FILE: design/cigar_op_generator.sv
`timescale 1ns / 1ps
// Each block passes the input stage, the operation list stage and the result register.
// Throughput: one operation per cycle while the result port is ready; a block gives
// operations (1 to 5), drained from its operation list through the single result register.
// Reset: arst_n clears the valid flags, the previous block ends and paired_end to zero.
// The configuration port is always ready.
module cigar_op_generator #(
	parameter int GENOME_BITS  = cog_pkg::GENOME_BITS_DEF,
	parameter int READ_LEN_MAX = cog_pkg::READ_LEN_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cog_cfg_if.sink    cfg,
	cog_blk_if.sink    blocks,
	cog_op_if.source   ops
);

	localparam int ReadW  = $clog2(READ_LEN_MAX) + 1;
	localparam int MateW  = $clog2(READ_LEN_MAX);
	localparam int DW     = ReadW + 2;
	localparam int GsumW  = GENOME_BITS + 1;
	localparam int RsumW  = ReadW + 1;
	localparam int OpLenW = cog_pkg::OP_LEN_W;
	localparam int NS     = cog_pkg::NUM_SLOTS;
	localparam logic signed [DW-1:0] OneX = 1;

	// configuration
	logic paired_q;

	// input stage
	logic                            valid_s1;
	logic                            first_s1;
	logic                            last_s1;
	logic [GENOME_BITS-1:0]          g_s1;
	logic [ReadW-1:0]                r_s1;
	logic [MateW-1:0]                len_s1;
	logic signed [cog_pkg::JC_W-1:0] jc_s1;
	logic                            annot_s1;
	logic                            strand_s1;
	logic [MateW-1:0]                m1_s1;
	logic [MateW-1:0]                m2_s1;
	logic [ReadW-1:0]                pair_s1;

	// state carried between blocks
	logic [GENOME_BITS-1:0] prev_g_q;
	logic [ReadW-1:0]       prev_r_q;

	// operation list stage
	cog_pkg::op_kind_t          kind_s2 [NS];
	logic signed [OpLenW-1:0]   len_s2  [NS];
	logic [NS-1:0]              pend_s2;
	logic                       last_s2;

	// result register
	logic                       out_valid_q;
	cog_pkg::op_kind_t          out_kind_q;
	logic signed [OpLenW-1:0]   out_len_q;
	logic                       out_last_q;

	// combinational
	cog_pkg::op_kind_t          kind_c [NS];
	logic signed [OpLenW-1:0]   len_c  [NS];
	logic [NS-1:0]              v_c;
	logic [MateW-1:0]           mate;
	logic signed [DW-1:0]       r_x, mate_x, prev_r_x, len_x, pair_x, end_x;
	logic signed [DW-1:0]       lead_first, lead_mate, tail_gap, ins_len, trail_len;
	logic                       r_lt_mate;
	logic [GsumW-1:0]           gdiff;
	logic                       overlap;
	logic [GsumW-1:0]           gsum;
	logic [RsumW-1:0]           rsum;
	logic                       out_free, pop, list_free, s1_move;
	logic [NS-1:0]              sel, pend_left;
	cog_pkg::op_kind_t          pick_kind;
	logic signed [OpLenW-1:0]   pick_len;

	function automatic logic is_pos(input logic signed [DW-1:0] x);
		is_pos = !x[DW-1] && (x != '0);
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paired_q <= 1'b0;
		end else if (cfg.valid) begin
			paired_q <= cfg.paired_end;
		end
	end

	// list drain and handshake
	assign out_free  = !out_valid_q || ops.ready;
	assign pop       = (pend_s2 != '0) && out_free;
	assign sel       = pend_s2 & (~pend_s2 + NS'(1));
	assign pend_left = pend_s2 & ~sel;
	assign list_free = (pend_s2 == '0) || (pop && (pend_left == '0));
	assign s1_move   = valid_s1 && list_free;
	assign blocks.ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (blocks.ready) begin
			valid_s1 <= blocks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (blocks.valid && blocks.ready) begin
			first_s1  <= blocks.first_block;
			last_s1   <= blocks.last_block;
			g_s1      <= blocks.genome_start;
			r_s1      <= blocks.read_start;
			len_s1    <= blocks.block_length;
			jc_s1     <= blocks.junction_code;
			annot_s1  <= blocks.annotated;
			strand_s1 <= blocks.strand;
			m1_s1     <= blocks.mate1_length;
			m2_s1     <= blocks.mate2_length;
			pair_s1   <= blocks.pair_length;
		end
	end

	// operation lengths for the block in the input stage
	always_comb begin
		mate     = (paired_q && strand_s1) ? m2_s1 : m1_s1;
		r_x      = $signed(DW'(r_s1));
		mate_x   = $signed(DW'(mate));
		prev_r_x = $signed(DW'(prev_r_q));
		len_x    = $signed(DW'(len_s1));
		pair_x   = $signed(DW'(pair_s1));
		r_lt_mate = r_s1 < ReadW'(mate);

		tail_gap   = r_x - mate_x - OneX;
		lead_first = r_lt_mate ? r_x : tail_gap;
		lead_mate  = mate_x - prev_r_x;
		ins_len    = r_x - prev_r_x;
		end_x      = r_lt_mate ? mate_x : pair_x;
		trail_len  = end_x - r_x - len_x;

		// borrow out of the subtraction marks overlapping mates; the same word,
		// read as signed, is the negative overlap length
		gdiff   = {1'b0, g_s1} - {1'b0, prev_g_q};
		overlap = gdiff[GsumW-1];

		gsum = {1'b0, g_s1} + GsumW'(len_s1);
		rsum = {1'b0, r_s1} + RsumW'(len_s1);
	end

	// fill the fixed slots of the operation list
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			kind_c[i] = cog_pkg::OP_S;
			len_c[i]  = '0;
			v_c[i]    = 1'b0;
		end

		len_c[cog_pkg::SLOT_GAP] = OpLenW'($signed(gdiff));

		if (first_s1) begin
			len_c[cog_pkg::SLOT_LEAD] = OpLenW'(lead_first);
			v_c[cog_pkg::SLOT_LEAD]   = is_pos(lead_first);
		end else if (overlap) begin
			kind_c[cog_pkg::SLOT_GAP] = cog_pkg::OP_P;
			v_c[cog_pkg::SLOT_GAP]    = 1'b1;
		end else if (jc_s1 == cog_pkg::MATE_GAP_CODE) begin
			len_c[cog_pkg::SLOT_LEAD]  = OpLenW'(lead_mate);
			v_c[cog_pkg::SLOT_LEAD]    = is_pos(lead_mate);
			kind_c[cog_pkg::SLOT_GAP]  = cog_pkg::OP_P;
			v_c[cog_pkg::SLOT_GAP]     = 1'b1;
			len_c[cog_pkg::SLOT_TAILG] = OpLenW'(tail_gap);
			v_c[cog_pkg::SLOT_TAILG]   = is_pos(tail_gap);
		end else begin
			kind_c[cog_pkg::SLOT_LEAD] = cog_pkg::OP_I;
			len_c[cog_pkg::SLOT_LEAD]  = OpLenW'(ins_len);
			v_c[cog_pkg::SLOT_LEAD]    = is_pos(ins_len);
			// canonical or annotated junctions always give N, even of length zero
			if (!jc_s1[cog_pkg::JC_W-1] || annot_s1) begin
				kind_c[cog_pkg::SLOT_GAP] = cog_pkg::OP_N;
				v_c[cog_pkg::SLOT_GAP]    = 1'b1;
			end else begin
				kind_c[cog_pkg::SLOT_GAP] = cog_pkg::OP_D;
				v_c[cog_pkg::SLOT_GAP]    = (gdiff != '0);
			end
		end

		kind_c[cog_pkg::SLOT_MATCH] = cog_pkg::OP_M;
		len_c[cog_pkg::SLOT_MATCH]  = OpLenW'(len_s1);
		v_c[cog_pkg::SLOT_MATCH]    = 1'b1;

		len_c[cog_pkg::SLOT_CLIP] = OpLenW'(trail_len);
		v_c[cog_pkg::SLOT_CLIP]   = last_s1 && is_pos(trail_len);
	end

	// advance the block ends when the block leaves the input stage; saturate on overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_g_q <= '0;
			prev_r_q <= '0;
		end else if (s1_move) begin
			prev_g_q <= gsum[GsumW-1] ? '1 : gsum[GENOME_BITS-1:0];
			prev_r_q <= rsum[RsumW-1] ? '1 : rsum[ReadW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (s1_move) begin
			pend_s2 <= v_c;
		end else if (pop) begin
			pend_s2 <= pend_left;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			kind_s2 <= kind_c;
			len_s2  <= len_c;
			last_s2 <= last_s1;
		end
	end

	// pick the lowest pending slot
	always_comb begin
		pick_kind = cog_pkg::OP_M;
		pick_len  = '0;
		for (int i = 0; i < NS; i++) begin
			if (sel[i]) begin
				pick_kind = kind_s2[i];
				pick_len  = len_s2[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (ops.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_kind_q <= pick_kind;
			out_len_q  <= pick_len;
			out_last_q <= last_s2 && (pend_left == '0);
		end
	end

	assign ops.valid     = out_valid_q;
	assign ops.op_kind   = out_kind_q;
	assign ops.op_length = out_len_q;
	assign ops.last_op   = out_last_q;

	// a freshly loaded list always holds its match operation
	a_list_has_match: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> pend_s2[cog_pkg::SLOT_MATCH])
		else $error("operation list loaded without M");

	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> $onehot(sel))
		else $error("drain select not one-hot");

	a_pop_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped operation not presented");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_move) |=> valid_s1)
		else $error("stalled block dropped from input stage");

endmodule
